/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the address parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ipv6p_pkg.sv */
// Types and constants of the IPv6 text address parser.
`default_nettype none

package ipv6p_pkg;

   localparam int CHAR_W  = 8;
   localparam int GROUP_W = 16;
   localparam int HALF_W  = 64;

   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_END   = 8'h00;

   localparam logic [3:0] NO_GAP     = 4'hf;
   localparam logic [3:0] NUM_GROUPS = 4'd8;
   localparam logic [3:0] MAX_LEAD_V4 = 4'd6;
   localparam logic [2:0] MAX_DIGITS = 3'd4;

   localparam logic [15:0] BCD_MAX    = 16'h0255;
   localparam logic [7:0]  BCD_TENS   = 8'hf0;
   localparam logic [7:0]  BCD_TENS_MAX = 8'h90;
   localparam logic [3:0]  BCD_UNIT_MAX = 4'd9;
   localparam logic [11:0] OCTET_MAX  = 12'd255;

   typedef enum logic [2:0] {
      PH_START,
      PH_LEAD,
      PH_TOP,
      PH_SEP,
      PH_HEX,
      PH_OCT_B,
      PH_OCT_C,
      PH_OCT_D
   } phase_type;

   typedef logic [GROUP_W-1:0] group_type;

endpackage

`default_nettype wire

/* rtl/ipv6p_req_if.sv */
// Character channel into the address parser.
`default_nettype none

interface ipv6p_req_if;
   import ipv6p_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;

   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

`default_nettype wire

/* rtl/ipv6p_rsp_if.sv */
// Result channel out of the address parser.
`default_nettype none

interface ipv6p_rsp_if;
   import ipv6p_pkg::*;

   logic              valid;
   logic              ready;
   logic [HALF_W-1:0] address_high;
   logic [HALF_W-1:0] address_low;
   logic              ok;

   modport source (output valid, output address_high, output address_low, output ok,
                   input ready);
   modport sink   (input valid, input address_high, input address_low, input ok,
                   output ready);
endinterface

`default_nettype wire

/* rtl/ipv6_text_address_parser_unit.sv */
// IPv6 text address parser: one character per word in, one 128-bit address per string out.
//
// req_in carries one ASCII character per word; a zero character ends the string.
// Every other character updates the parse state in the cycle it is accepted, so a
// new word can be taken in every cycle. The terminator loads the output register
// and rsp_out shows the address in the cycle after the terminator was accepted, with
// ok low and a zero address if the text was not a valid address. The parse state
// returns to its start on the same edge, so the next string may follow at once.
// Throughput is one character per cycle, set by the per-character update of the
// parse state. The output register holds one result; while it is full and the
// receiver holds rsp_out.ready low, req_in.ready is low and no word is taken.
// When it is being emptied in the same cycle, a new word is still taken.
// Reset empties the output register and puts the parser at the start of a string.
`default_nettype none

module ipv6_text_address_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   ipv6p_req_if.sink        req_in,
   ipv6p_rsp_if.source      rsp_out
);
   import ipv6p_pkg::*;

`include "assert_macros.svh"

   // Parse state
   group_type   store_ff [8];
   group_type   store_in [8];
   logic [3:0]  count_ff, count_in;
   logic [3:0]  gap_ff, gap_in;
   logic [15:0] acc_ff, acc_in;
   logic [2:0]  dc_ff, dc_in;
   logic        failed_ff, failed_in;
   phase_type   phase_ff, phase_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [HALF_W-1:0] rsp_high_ff, rsp_low_ff;
   logic              rsp_ok_ff;

   // Character decode
   logic [7:0]  ch;
   logic        take, term, step;
   logic        is_colon, is_dot, is_digit, is_lower, is_upper, is_hex;
   logic [3:0]  hv;
   logic [3:0]  dv;
   logic [2:0]  gi, gi1;
   logic [11:0] oct_prod;
   logic [9:0]  bcd_val;
   logic        bcd_bad;

   // Completion
   group_type          fin_store [8];
   logic [3:0]         fin_count;
   logic               fin_ok;
   logic [127:0]       fin_flat;
   logic [255:0]       fin_dbl;
   logic [127:0]       fin_rot;
   group_type          res [8];
   logic [4:0]         tail_sum;
   logic [HALF_W-1:0]  res_high, res_low;

   assign req_in.ready = !rsp_valid_ff || rsp_out.ready;
   assign take = req_in.valid && req_in.ready;
   assign ch   = req_in.character;
   assign term = (ch == CH_END);
   assign step = take && !term && !failed_ff;

   assign is_colon = (ch == CH_COLON);
   assign is_dot   = (ch == CH_DOT);
   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_lower = (ch >= CH_LA) && (ch <= CH_LF);
   assign is_upper = (ch >= CH_UA) && (ch <= CH_UF);
   assign is_hex   = is_digit || is_lower || is_upper;
   assign dv       = 4'(ch - CH_ZERO);

   always_comb begin
      hv = dv;
      if (is_lower) begin
         hv = 4'(ch - CH_LA + 8'd10);
      end else if (is_upper) begin
         hv = 4'(ch - CH_UA + 8'd10);
      end
   end

   assign gi       = count_ff[2:0];
   assign gi1      = gi + 3'd1;
   assign oct_prod = {4'b0, acc_ff[7:0]} * 12'd10 + {8'b0, dv};

   // The first octet of the dotted part arrives as hex digits and is read as BCD.
   assign bcd_bad = (count_ff > MAX_LEAD_V4) || (acc_ff > BCD_MAX)
                 || ((acc_ff[7:0] & BCD_TENS) > BCD_TENS_MAX)
                 || (acc_ff[3:0] > BCD_UNIT_MAX);
   assign bcd_val = {8'b0, acc_ff[9:8]} * 10'd100 + {6'b0, acc_ff[7:4]} * 10'd10
                  + {6'b0, acc_ff[3:0]};

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (take && term) begin
         phase_in = PH_START;
      end else if (step) begin
         case (phase_ff)
            PH_START: begin
               if (is_colon) phase_in = PH_LEAD;
               else if (is_hex) phase_in = PH_HEX;
            end
            PH_LEAD: begin
               if (is_colon) phase_in = PH_TOP;
            end
            PH_TOP, PH_SEP: begin
               if (is_colon) phase_in = PH_TOP;
               else if (is_hex) phase_in = PH_HEX;
            end
            PH_HEX: begin
               if (is_colon) phase_in = PH_SEP;
               else if (is_dot) phase_in = PH_OCT_B;
            end
            PH_OCT_B: begin
               if (is_dot) phase_in = PH_OCT_C;
            end
            PH_OCT_C: begin
               if (is_dot) phase_in = PH_OCT_D;
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // Datapath state
   always_comb begin
      store_in  = store_ff;
      count_in  = count_ff;
      gap_in    = gap_ff;
      acc_in    = acc_ff;
      dc_in     = dc_ff;
      failed_in = failed_ff;
      if (take && term) begin
         for (int k = 0; k < 8; k++) store_in[k] = '0;
         count_in  = '0;
         gap_in    = NO_GAP;
         acc_in    = '0;
         dc_in     = '0;
         failed_in = 1'b0;
      end else if (step) begin
         case (phase_ff)
            PH_START, PH_TOP, PH_SEP: begin
               if (phase_ff == PH_START && is_colon) begin
                  // Wait for the second colon of a leading double colon.
               end else if (count_ff >= NUM_GROUPS) begin
                  failed_in = 1'b1;
               end else if (is_colon) begin
                  if (gap_ff != NO_GAP) begin
                     failed_in = 1'b1;
                  end else begin
                     store_in[gi] = '0;
                     count_in     = count_ff + 4'd1;
                     gap_in       = count_ff + 4'd1;
                  end
               end else if (is_hex) begin
                  acc_in = {12'b0, hv};
                  dc_in  = 3'd1;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_LEAD: begin
               if (is_colon) begin
                  store_in[0] = '0;
                  count_in    = 4'd1;
                  gap_in      = 4'd1;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_HEX: begin
               if (is_hex) begin
                  if (dc_ff >= MAX_DIGITS) begin
                     failed_in = 1'b1;
                  end else begin
                     acc_in = {acc_ff[11:0], hv};
                     dc_in  = dc_ff + 3'd1;
                  end
               end else if (is_colon) begin
                  store_in[gi] = acc_ff;
                  count_in     = count_ff + 4'd1;
               end else if (is_dot) begin
                  if (bcd_bad) begin
                     failed_in = 1'b1;
                  end else begin
                     store_in[gi] = {bcd_val[7:0], 8'h00};
                     acc_in       = '0;
                     dc_in        = '0;
                  end
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_OCT_B, PH_OCT_C, PH_OCT_D: begin
               if (is_digit) begin
                  acc_in = {4'b0, oct_prod};
                  dc_in  = 3'd1;
                  if (oct_prod > OCTET_MAX) failed_in = 1'b1;
               end else if (!is_dot || dc_ff == 3'd0 || phase_ff == PH_OCT_D) begin
                  failed_in = 1'b1;
               end else begin
                  if (phase_ff == PH_OCT_B) begin
                     store_in[gi][7:0] = acc_ff[7:0];
                  end else begin
                     store_in[gi1] = {acc_ff[7:0], 8'h00};
                  end
                  acc_in = '0;
                  dc_in  = '0;
               end
            end
            default: failed_in = 1'b1;
         endcase
      end
   end

   // Close the last group, then expand the double colon.
   always_comb begin
      fin_store = store_ff;
      fin_count = count_ff;
      fin_ok    = !failed_ff;
      if (phase_ff == PH_HEX) begin
         fin_store[gi] = acc_ff;
         fin_count     = count_ff + 4'd1;
      end else if (phase_ff == PH_OCT_D && dc_ff != 3'd0) begin
         fin_store[gi1][7:0] = acc_ff[7:0];
         fin_count           = count_ff + 4'd2;
      end else if (phase_ff != PH_TOP && phase_ff != PH_START) begin
         fin_ok = 1'b0;
      end
      if (fin_count > NUM_GROUPS) fin_ok = 1'b0;
      if (gap_ff == NO_GAP && fin_count != NUM_GROUPS) fin_ok = 1'b0;
   end

   always_comb begin
      for (int k = 0; k < 8; k++) fin_flat[16*k +: 16] = fin_store[k];
   end

   // Groups after the gap are the stored ones rotated down by the group count.
   assign fin_dbl = {fin_flat, fin_flat};
   assign fin_rot = fin_dbl[{fin_count[2:0], 4'b0} +: 128];

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         tail_sum = 5'(k) + {1'b0, fin_count};
         if (gap_ff == NO_GAP || 4'(k) < gap_ff) begin
            res[k] = fin_store[k];
         end else if (tail_sum >= {1'b0, gap_ff} + 5'd8) begin
            res[k] = fin_rot[16*k +: 16];
         end else begin
            res[k] = '0;
         end
      end
   end

   assign res_high = fin_ok ? {res[0], res[1], res[2], res[3]} : '0;
   assign res_low  = fin_ok ? {res[4], res[5], res[6], res[7]} : '0;

   assign rsp_valid_in = (take && term) || (rsp_valid_ff && !rsp_out.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         gap_ff       <= NO_GAP;
         acc_ff       <= '0;
         dc_ff        <= '0;
         failed_ff    <= 1'b0;
         phase_ff     <= PH_START;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 8; k++) store_ff[k] <= '0;
      end else begin
         count_ff     <= count_in;
         gap_ff       <= gap_in;
         acc_ff       <= acc_in;
         dc_ff        <= dc_in;
         failed_ff    <= failed_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         store_ff     <= store_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && term) begin
         rsp_high_ff <= res_high;
         rsp_low_ff  <= res_low;
         rsp_ok_ff   <= fin_ok;
      end
   end

   assign rsp_out.valid        = rsp_valid_ff;
   assign rsp_out.address_high = rsp_high_ff;
   assign rsp_out.address_low  = rsp_low_ff;
   assign rsp_out.ok           = rsp_ok_ff;

   `ASSERT_IMPLY(a_bad_is_zero, clock, reset, rsp_valid_ff && !rsp_ok_ff, rsp_high_ff == '0 && rsp_low_ff == '0, "failed result carries a nonzero address")
   `ASSERT_NEXT(a_term_restarts, clock, reset, take && term, rsp_valid_ff && phase_ff == PH_START && count_ff == '0 && !failed_ff, "terminator did not produce a result and restart")
   `ASSERT_NEXT(a_no_spurious, clock, reset, take && !term && !rsp_valid_ff, !rsp_valid_ff, "result appeared without a terminator")
   `ASSERT_IMPLY(a_count_range, clock, reset, !failed_ff, count_ff <= NUM_GROUPS && (gap_ff == NO_GAP || gap_ff <= count_ff), "group count or gap out of range")

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for the IPv6 text address parser: directed and random address text checked word by word.
module tb_top;
   import ipv6p_pkg::*;

   localparam int TOTAL_ITEMS  = 1950;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 80;

   // Keeps its own copy of the parse state and the addresses still to come out.
   class addr_scoreboard;
      typedef struct {
         logic [HALF_W-1:0] high;
         logic [HALF_W-1:0] low;
         logic              ok;
      } address_word_type;

      group_type        groups[8];
      int unsigned      group_cnt;
      logic [3:0]       gap_at;
      logic [15:0]      acc;
      int unsigned      ndigits;
      phase_type        phase;
      bit               errored;
      address_word_type awaited[$];
      int unsigned      mismatches;
      int unsigned      addresses_checked;
      int unsigned      good_addresses;
      int unsigned      chars_parsed;
      int unsigned      items_seen;

      function new();
         clear_parse();
      endfunction

      function void clear_parse();
         foreach (groups[i]) groups[i] = '0;
         group_cnt = 0;
         gap_at    = NO_GAP;
         acc       = '0;
         ndigits   = 0;
         phase     = PH_START;
         errored   = 1'b0;
      endfunction

      function int hex_of(logic [7:0] c);
         if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
         if (c >= CH_LA && c <= CH_LF) return c - CH_LA + 10;
         if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
         return -1;
      endfunction

      // First character of a group, or the second colon of a double colon.
      function void open_group(logic [7:0] c);
         int h;
         if (group_cnt >= NUM_GROUPS) begin
            errored = 1'b1;
            return;
         end
         if (c == CH_COLON) begin
            if (gap_at != NO_GAP) begin
               errored = 1'b1;
               return;
            end
            groups[group_cnt % 8] = '0;
            group_cnt++;
            gap_at = 4'(group_cnt);
            phase  = PH_TOP;
            return;
         end
         h = hex_of(c);
         if (h < 0) begin
            errored = 1'b1;
            return;
         end
         acc     = 16'(h);
         ndigits = 1;
         phase   = PH_HEX;
      endfunction

      // Characters of the second to fourth octets of a dotted tail.
      function void octet_char(logic [7:0] c);
         int unsigned gi;
         gi = group_cnt % 8;
         if (c >= CH_ZERO && c <= CH_NINE) begin
            acc = 16'(acc * 10 + (c - CH_ZERO));
            if (acc > OCTET_MAX) errored = 1'b1;
            ndigits = 1;
            return;
         end
         if (c != CH_DOT || ndigits == 0 || phase == PH_OCT_D) begin
            errored = 1'b1;
            return;
         end
         if (phase == PH_OCT_B) groups[gi] = {groups[gi][15:8], acc[7:0]};
         else groups[(gi + 1) % 8] = {acc[7:0], 8'h00};
         phase   = (phase == PH_OCT_B) ? PH_OCT_C : PH_OCT_D;
         acc     = '0;
         ndigits = 0;
      endfunction

      function void close_string();
         address_word_type r;
         group_type        full[8];
         bit               good;
         int unsigned      gi;
         int unsigned      ncopy;
         int unsigned      tail;
         good = !errored;
         foreach (full[i]) full[i] = '0;
         if (good) begin
            if (phase == PH_HEX) begin
               groups[group_cnt % 8] = acc;
               group_cnt++;
            end else if (phase == PH_OCT_D && ndigits != 0) begin
               gi = (group_cnt + 1) % 8;
               groups[gi] = {groups[gi][15:8], acc[7:0]};
               group_cnt += 2;
            end else if (phase != PH_TOP && phase != PH_START) begin
               good = 1'b0;
            end
         end
         if (good && group_cnt > NUM_GROUPS) good = 1'b0;
         if (good) begin
            if (gap_at != NO_GAP) begin
               // The groups after the double colon move to the end of the address.
               ncopy = group_cnt - gap_at;
               tail  = 8 - ncopy;
               for (int i = 0; i < 8; i++) begin
                  if (i < gap_at) full[i] = groups[i];
                  else if (i >= tail) full[i] = groups[(gap_at + i - tail) % 8];
                  else full[i] = '0;
               end
            end else if (group_cnt != NUM_GROUPS) begin
               good = 1'b0;
            end else begin
               full = groups;
            end
         end
         r.ok   = good;
         r.high = good ? {full[0], full[1], full[2], full[3]} : '0;
         r.low  = good ? {full[4], full[5], full[6], full[7]} : '0;
         awaited.push_back(r);
         clear_parse();
      endfunction

      function void note_char(logic [7:0] c);
         int          h;
         logic [11:0] dec;
         items_seen++;
         if (c == CH_END) begin
            close_string();
            return;
         end
         if (errored) return;
         chars_parsed++;
         case (phase)
            PH_START: begin
               if (c == CH_COLON) phase = PH_LEAD;
               else open_group(c);
            end
            PH_LEAD: begin
               if (c == CH_COLON) begin
                  groups[0] = '0;
                  group_cnt = 1;
                  gap_at    = 4'd1;
                  phase     = PH_TOP;
               end else begin
                  errored = 1'b1;
               end
            end
            PH_TOP, PH_SEP: open_group(c);
            PH_HEX: begin
               h = hex_of(c);
               if (h >= 0) begin
                  if (ndigits >= MAX_DIGITS) errored = 1'b1;
                  else begin
                     acc = {acc[11:0], h[3:0]};
                     ndigits++;
                  end
               end else if (c == CH_COLON) begin
                  groups[group_cnt % 8] = acc;
                  group_cnt++;
                  phase = PH_SEP;
               end else if (c == CH_DOT) begin
                  // The group read so far is the first octet, taken as BCD.
                  if (group_cnt > MAX_LEAD_V4 || acc > BCD_MAX ||
                      (acc[7:0] & BCD_TENS) > BCD_TENS_MAX || acc[3:0] > BCD_UNIT_MAX) begin
                     errored = 1'b1;
                  end else begin
                     dec = 12'(acc[11:8] * 100 + acc[7:4] * 10 + acc[3:0]);
                     groups[group_cnt % 8] = {dec[7:0], 8'h00};
                     acc     = '0;
                     ndigits = 0;
                     phase   = PH_OCT_B;
                  end
               end else begin
                  errored = 1'b1;
               end
            end
            default: octet_char(c);
         endcase
      endfunction

      task report(string msg);
         $display("%0t: address mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task check_result(logic [HALF_W-1:0] high, logic [HALF_W-1:0] low, logic ok);
         address_word_type want;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected word %h_%h ok=%b", high, low, ok));
            return;
         end
         want = awaited.pop_front();
         addresses_checked++;
         if (want.ok) good_addresses++;
         if (high !== want.high)
            report($sformatf("address_high %h, expected %h", high, want.high));
         if (low !== want.low)
            report($sformatf("address_low %h, expected %h", low, want.low));
         if (ok !== want.ok)
            report($sformatf("ok %b, expected %b", ok, want.ok));
      endtask

      task drain_check();
         if (awaited.size() != 0)
            report($sformatf("%0d addresses never came out", awaited.size()));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   ipv6p_req_if req_bus();
   ipv6p_rsp_if rsp_bus();

   ipv6_text_address_parser_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_bus),
      .rsp_out (rsp_bus)
   );

   addr_scoreboard sb = new();
   bit             calm;
   bit             hold_wanted;
   bit             hold_served;
   logic [7:0]     text_buf[$];
   int unsigned    stall_cycles;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) sb.note_char(req_bus.character);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.address_high, rsp_bus.address_low, rsp_bus.ok);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Receiver: random stalls, plus one long hold so that the parser backs up.
   initial begin
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_wanted && !hold_served) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_served = 1'b1;
         end
         rsp_bus.ready <= calm || ($urandom_range(99) >= 10);
         @(posedge clock);
      end
   end

   task automatic send_char(logic [7:0] c);
      if (!calm && $urandom_range(99) < 10) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.character <= c;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_chars(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic send_string(string s);
      send_chars(s);
      send_char(CH_END);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_char();
      string alphabet;
      alphabet = ":.0123456789abcdefABCDEFg";
      if ($urandom_range(1)) return 8'($urandom_range(1, 255));
      return alphabet[$urandom_range(0, alphabet.len() - 1)];
   endfunction

   function automatic void put_hex_group();
      int unsigned n;
      int unsigned d;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
         d = $urandom_range(0, 15);
         if (d < 10) text_buf.push_back(8'(CH_ZERO + d));
         else if ($urandom_range(1)) text_buf.push_back(8'(CH_LA + d - 10));
         else text_buf.push_back(8'(CH_UA + d - 10));
      end
   endfunction

   function automatic int unsigned pick_octet();
      case ($urandom_range(15))
         0: return $urandom_range(256, 999);
         1: return 0;
         2: return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // Decimal octet text, now and then with leading zeros up to max_len digits.
   function automatic void put_octet(int unsigned value, int unsigned max_len);
      string       s;
      int unsigned pad;
      s   = $sformatf("%0d", value);
      pad = 0;
      if ($urandom_range(3) == 0 && s.len() < max_len) pad = $urandom_range(0, max_len - s.len());
      repeat (pad) text_buf.push_back(CH_ZERO);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endfunction

   function automatic void put_v4_tail();
      put_octet(pick_octet(), 4);
      for (int i = 0; i < 3; i++) begin
         text_buf.push_back(CH_DOT);
         put_octet(pick_octet(), 5);
      end
   endfunction

   function automatic void build_address();
      bit          v4;
      int unsigned slots;
      int unsigned n;
      int unsigned k;
      v4    = ($urandom_range(2) == 0);
      slots = v4 ? 6 : 8;
      if ($urandom_range(9) == 0) slots = $urandom_range(slots - 1, slots + 1);
      if ($urandom_range(1)) begin
         n = $urandom_range(0, slots - 1);
         k = $urandom_range(0, n);
         for (int i = 0; i < k; i++) begin
            put_hex_group();
            if (i + 1 < k) text_buf.push_back(CH_COLON);
         end
         text_buf.push_back(CH_COLON);
         text_buf.push_back(CH_COLON);
         for (int i = 0; i < n - k; i++) begin
            if (i > 0) text_buf.push_back(CH_COLON);
            put_hex_group();
         end
         if (v4) begin
            if (n > k) text_buf.push_back(CH_COLON);
            put_v4_tail();
         end
      end else begin
         for (int i = 0; i < slots; i++) begin
            if (i > 0) text_buf.push_back(CH_COLON);
            put_hex_group();
         end
         if (v4) begin
            text_buf.push_back(CH_COLON);
            put_v4_tail();
         end
      end
   endfunction

   function automatic void mutate_text();
      int unsigned pos;
      if (text_buf.size() == 0) begin
         text_buf.push_back(random_char());
         return;
      end
      pos = $urandom_range(0, text_buf.size() - 1);
      case ($urandom_range(3))
         0: text_buf[pos] = random_char();
         1: text_buf.insert(pos, random_char());
         2: text_buf.delete(pos);
         default: while (text_buf.size() > pos) void'(text_buf.pop_back());
      endcase
   endfunction

   function automatic void build_random_text();
      int unsigned r;
      text_buf.delete();
      r = $urandom_range(99);
      if (r < 10) begin
         repeat ($urandom_range(0, 10)) text_buf.push_back(random_char());
      end else begin
         build_address();
         if (r < 30) mutate_text();
      end
   endfunction

   initial begin
      int unsigned n;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.character <= CH_END;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_string("");
      send_string("::");
      send_string("1:2:3:4:5:6:7:8");
      send_string("FFFF:ffff:AbCd:0:0:0:0:1");
      send_string("::1");
      send_string("1::");
      send_string("1:2:3:4:5:6:7::");
      send_string("12345::");
      send_string("1:2:3:4:5:6:7:8:9");
      send_string("1:2:3:4:5:6:7:8:");
      send_string("1:2:3");
      send_string(":::");
      send_string("1::2::3");
      send_string("::ffff:0255.00.255.9");
      send_string("1:2:3:4:5:6:1.2.3.4");
      send_string("1:2:3:4:5:6:7:1.2.3.4");
      send_string("::256.1.1.1");
      send_string("::1.256.1.1");
      send_string("::1a0.1.1.1");
      send_string("::1.2.3");
      send_string("::1.2.3.");
      send_string(":x");
      send_string("a:");
      // Anything after an error, high characters included, must leave the result alone.
      send_chars("1:");
      send_char(8'hff);
      send_string(":2:3:4:5:6:7");
      send_chars("1:2:3:4:5:6:7:8");
      send_char(8'h80);
      send_char(CH_END);
      wait_drained();

      n = 0;
      while (sb.items_seen < TOTAL_ITEMS) begin
         calm = (n >= 40 && n < 60);
         if (n == 20) hold_wanted = 1'b1;
         build_random_text();
         foreach (text_buf[i]) send_char(text_buf[i]);
         send_char(CH_END);
         n++;
      end
      calm = 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      sb.drain_check();

      $display("Checked %0d addresses (%0d valid) built from %0d parsed characters,",
               sb.addresses_checked, sb.good_addresses, sb.chars_parsed);
      $display("with random stalls on both sides, a long output hold and a drained pause.");
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ipv6p_pkg.sv
rtl/ipv6p_req_if.sv
rtl/ipv6p_rsp_if.sv
rtl/ipv6_text_address_parser_unit.sv
sim/tb_top.sv
